### src/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, constants and rounding helpers of the UV sphere strip
// vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam int unsigned MAX_DIVISIONS_DEF = 240;
   localparam logic [15:0] RADIUS_RST        = 16'd256;
   localparam logic [7:0]  COUNT_RST         = 8'd32;

   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   // angle divider: remainder < 2*stacks (9 bits), quotient below pi/2 in Q2.30
   localparam int ANG_DEN_W = 9;
   localparam int ANG_QUO_W = 31;
   // texture divider: count 8 bits, quotient up to 65536
   localparam int TEX_DEN_W = 8;
   localparam int TEX_QUO_W = 17;

   localparam int HORNER_STEPS = 5;
   localparam int SC_LAT  = 2 + ANG_QUO_W + 1 + 3 * HORNER_STEPS + 2;
   localparam int VTX_LAT = 3;
   localparam int TEX_DLY = SC_LAT + VTX_LAT - TEX_QUO_W;

   localparam logic [7:0] SIN_DIV [HORNER_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   localparam logic [7:0] COS_DIV [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12};
   localparam logic [31:0] SIN_RCP [HORNER_STEPS] = '{
      32'(64'h1_0000_0000 / 110), 32'(64'h1_0000_0000 / 72),
      32'(64'h1_0000_0000 / 42),  32'(64'h1_0000_0000 / 20),
      32'(64'h1_0000_0000 / 6)};
   localparam logic [31:0] COS_RCP [HORNER_STEPS] = '{
      32'(64'h1_0000_0000 / 132), 32'(64'h1_0000_0000 / 90),
      32'(64'h1_0000_0000 / 56),  32'(64'h1_0000_0000 / 30),
      32'(64'h1_0000_0000 / 12)};

   typedef enum logic [7:0] {
      CSR_RADIUS  = 8'd0,
      CSR_SLICES  = 8'd1,
      CSR_STACKS  = 8'd2,
      CSR_TEXTURE = 8'd3
   } csr_index_type;

   // values that ride along the Horner chain
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] x2;
      logic [1:0]  quad;
   } ang_carry_type;

   // round to nearest, halves away from zero
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int unsigned sh);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) return 16'sh7fff;
      else if (v < -64'sd32768) return 16'sh8000;
      else return v[15:0];
   endfunction

endpackage

### src/uvs_div.sv
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, one quotient bit per stage. The numerator's
// top DEN_W bits must already be below the denominator.
// ----------------------------------------------------------------------------
module uvs_div #(
   parameter int DEN_W = uvs_pkg::TEX_DEN_W,
   parameter int QUO_W = uvs_pkg::TEX_QUO_W
) (
   input  logic                   clock,
   input  logic [DEN_W+QUO_W-1:0] num_in,
   input  logic [DEN_W-1:0]       den_in,
   output logic [QUO_W-1:0]       quo_out
);

   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] low_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      logic [DEN_W-1:0] rem_p;
      logic [DEN_W-1:0] den_p;
      logic [QUO_W-1:0] low_p;
      logic [QUO_W-1:0] quo_p;
      logic [DEN_W:0]   trial;
      logic             ge;

      if (s == 0) begin : g_first
         assign rem_p = num_in[DEN_W+QUO_W-1:QUO_W];
         assign low_p = num_in[QUO_W-1:0];
         assign den_p = den_in;
         assign quo_p = '0;
      end else begin : g_next
         assign rem_p = rem_ff[s-1];
         assign low_p = low_ff[s-1];
         assign den_p = den_ff[s-1];
         assign quo_p = quo_ff[s-1];
      end

      assign trial = {rem_p, low_p[QUO_W-1-s]};
      assign ge    = (trial >= {1'b0, den_p});

      always_ff @(posedge clock) begin
         rem_ff[s] <= ge ? DEN_W'(trial - {1'b0, den_p}) : trial[DEN_W-1:0];
         low_ff[s] <= low_p;
         den_ff[s] <= den_p;
         quo_ff[s] <= {quo_p[QUO_W-2:0], ge};
      end
   end

   assign quo_out = quo_ff[QUO_W-1];

endmodule

### src/uvs_sincos.sv
// ----------------------------------------------------------------------------
// uvs_sincos
// Sine and cosine in Q2.30 of the angle num/den of a full turn: quadrant
// split, angle divider, then Taylor series in Horner form, one term per
// three stages.
// ----------------------------------------------------------------------------
module uvs_sincos (
   input  logic                          clock,
   input  logic [uvs_pkg::ANG_DEN_W-1:0] ang_num,
   input  logic [uvs_pkg::ANG_DEN_W-1:0] ang_den,
   output logic signed [31:0]            sin_out,
   output logic signed [31:0]            cos_out
);
   import uvs_pkg::*;

   localparam int DW = ANG_DEN_W;
   localparam int QW = ANG_QUO_W;
   localparam int NW = DW + QW;

   // quadrant split
   logic [DW+1:0] f_in, d1_in, d2_in, d3_in;
   logic [1:0]    q1_in;
   logic [DW+1:0] r1_in;
   logic [1:0]    q1_ff, q2_ff;
   logic [DW-1:0] r1_ff, den1_ff, den2_ff;
   logic [NW-1:0] num2_ff;

   always_comb begin
      f_in  = {ang_num, 2'b00};
      d1_in = (DW+2)'(ang_den);
      d2_in = {1'b0, ang_den, 1'b0};
      d3_in = d1_in + d2_in;
      if (f_in >= d3_in) begin
         q1_in = 2'd3;
         r1_in = f_in - d3_in;
      end else if (f_in >= d2_in) begin
         q1_in = 2'd2;
         r1_in = f_in - d2_in;
      end else if (f_in >= d1_in) begin
         q1_in = 2'd1;
         r1_in = f_in - d1_in;
      end else begin
         q1_in = 2'd0;
         r1_in = f_in;
      end
   end

   always_ff @(posedge clock) begin
      q1_ff   <= q1_in;
      r1_ff   <= r1_in[DW-1:0];
      den1_ff <= ang_den;
      q2_ff   <= q1_ff;
      den2_ff <= den1_ff;
      num2_ff <= NW'(r1_ff) * NW'(HALF_PI_Q30) + NW'(den1_ff >> 1);
   end

   logic [QW-1:0] x_div;

   uvs_div #(.DEN_W(DW), .QUO_W(QW)) u_div (
      .clock  (clock),
      .num_in (num2_ff),
      .den_in (den2_ff),
      .quo_out(x_div)
   );

   logic [1:0] qd_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_qdly
      if (s == 0) begin : g_first
         always_ff @(posedge clock) qd_ff[s] <= q2_ff;
      end else begin : g_next
         always_ff @(posedge clock) qd_ff[s] <= qd_ff[s-1];
      end
   end

   // x squared
   ang_carry_type carry0_ff;
   logic [61:0]   xx_in;

   assign xx_in = 62'(x_div) * 62'(x_div);

   always_ff @(posedge clock) begin
      carry0_ff.x    <= 32'(x_div);
      carry0_ff.x2   <= xx_in[61:30];
      carry0_ff.quad <= qd_ff[QW-1];
   end

   // Horner chain: A multiply by x2, B reciprocal estimate, C correct and 1-q
   ang_carry_type carrya_ff [HORNER_STEPS];
   ang_carry_type carryb_ff [HORNER_STEPS];
   ang_carry_type carryc_ff [HORNER_STEPS];
   logic [31:0]   sp_ff [HORNER_STEPS];
   logic [31:0]   cp_ff [HORNER_STEPS];
   logic [31:0]   sq_ff [HORNER_STEPS];
   logic [31:0]   cq_ff [HORNER_STEPS];
   logic [31:0]   sn_ff [HORNER_STEPS];
   logic [31:0]   cn_ff [HORNER_STEPS];
   logic [30:0]   ts_ff [HORNER_STEPS];
   logic [30:0]   tc_ff [HORNER_STEPS];

   for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
      ang_carry_type cprev;
      logic [30:0]   ts_prev, tc_prev;
      logic [62:0]   sa_in, ca_in;
      logic [63:0]   sb_in, cb_in;
      logic [39:0]   srem, crem;
      logic [32:0]   sqq, cqq;

      if (k == 0) begin : g_first
         assign cprev   = carry0_ff;
         assign ts_prev = Q30_ONE;
         assign tc_prev = Q30_ONE;
      end else begin : g_next
         assign cprev   = carryc_ff[k-1];
         assign ts_prev = ts_ff[k-1];
         assign tc_prev = tc_ff[k-1];
      end

      always_comb begin
         sa_in = 63'(cprev.x2) * 63'(ts_prev);
         ca_in = 63'(cprev.x2) * 63'(tc_prev);
         sb_in = 64'(sp_ff[k]) * 64'(SIN_RCP[k]);
         cb_in = 64'(cp_ff[k]) * 64'(COS_RCP[k]);
         srem  = 40'(sn_ff[k]) - 40'(sq_ff[k]) * 40'(SIN_DIV[k]);
         crem  = 40'(cn_ff[k]) - 40'(cq_ff[k]) * 40'(COS_DIV[k]);
         sqq   = (srem >= 40'(SIN_DIV[k])) ? 33'(sq_ff[k]) + 33'd1 : 33'(sq_ff[k]);
         cqq   = (crem >= 40'(COS_DIV[k])) ? 33'(cq_ff[k]) + 33'd1 : 33'(cq_ff[k]);
      end

      always_ff @(posedge clock) begin
         sp_ff[k]     <= sa_in[61:30];
         cp_ff[k]     <= ca_in[61:30];
         carrya_ff[k] <= cprev;
         sq_ff[k]     <= sb_in[63:32];
         cq_ff[k]     <= cb_in[63:32];
         sn_ff[k]     <= sp_ff[k];
         cn_ff[k]     <= cp_ff[k];
         carryb_ff[k] <= carrya_ff[k];
         ts_ff[k]     <= 31'(33'(Q30_ONE) - sqq);
         tc_ff[k]     <= 31'(33'(Q30_ONE) - cqq);
         carryc_ff[k] <= carryb_ff[k];
      end
   end

   // last terms: s = x*t, c = 1 - x2*t/2
   ang_carry_type    cfin;
   logic [62:0]      sf_in, cf_in;
   logic signed [31:0] s_ff, c_ff;
   logic [1:0]       qf_ff;
   logic signed [31:0] sin_ff, cos_ff;

   assign cfin  = carryc_ff[HORNER_STEPS-1];
   assign sf_in = 63'(cfin.x) * 63'(ts_ff[HORNER_STEPS-1]);
   assign cf_in = 63'(cfin.x2) * 63'(tc_ff[HORNER_STEPS-1]);

   always_ff @(posedge clock) begin
      s_ff  <= $signed(sf_in[61:30]);
      c_ff  <= $signed(32'(33'(Q30_ONE) - 33'(cf_in[61:31])));
      qf_ff <= cfin.quad;
      case (qf_ff)
         2'd0: begin
            sin_ff <= s_ff;
            cos_ff <= c_ff;
         end
         2'd1: begin
            sin_ff <= c_ff;
            cos_ff <= -s_ff;
         end
         2'd2: begin
            sin_ff <= -s_ff;
            cos_ff <= -c_ff;
         end
         default: begin
            sin_ff <= -c_ff;
            cos_ff <= s_ff;
         end
      endcase
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

### src/uv_sphere_strip_vertex_gen.sv
// ----------------------------------------------------------------------------
// uv_sphere_strip_vertex_gen
// Turns a (stack, slice) strip position into the upper and lower vertex of
// a UV sphere band plus texture coordinates, in fixed point.
//
//   channel  ports                         transfer
//   request  start, busy, req_*            start high while busy low
//   result   rsp_strobe, rsp_*             one cycle with rsp_strobe high
//   config   csr_valid, csr_ready, csr_*   csr_valid and csr_ready high
//
// One item per cycle; every result appears once its request has passed
// the pipeline (31-stage angle divider and Horner chain).
// busy stays low: nothing in the datapath stalls and the receiver cannot
// hold results off. Reset clears the pipeline valid bits and loads the
// register defaults.
// ----------------------------------------------------------------------------
module uv_sphere_strip_vertex_gen #(
   parameter int unsigned MAX_DIVISIONS = uvs_pkg::MAX_DIVISIONS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_stack_index,
   input  logic [7:0]         req_slice_index,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_upper_x,
   output logic signed [15:0] rsp_upper_y,
   output logic signed [15:0] rsp_upper_z,
   output logic signed [15:0] rsp_lower_x,
   output logic signed [15:0] rsp_lower_y,
   output logic signed [15:0] rsp_lower_z,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v_upper,
   output logic [16:0]        rsp_tex_v_lower,
   output logic               rsp_tex_valid,
   output logic               rsp_bad_index
);
   import uvs_pkg::*;

   typedef struct packed {
      logic valid;
      logic bad;
      logic pole_u;
      logic pole_l;
   } side_type;

   typedef struct packed {
      logic [16:0] u;
      logic [16:0] vu;
      logic [16:0] vl;
   } tex_type;

   localparam int TNW = TEX_DEN_W + TEX_QUO_W;

   // configuration registers
   logic [15:0] radius_ff;
   logic [7:0]  slices_ff, stacks_ff;
   logic        tex_on_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         slices_ff <= COUNT_RST;
         stacks_ff <= COUNT_RST;
         tex_on_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RADIUS:  radius_ff <= csr_wdata;
            CSR_SLICES:  slices_ff <= csr_wdata[7:0];
            CSR_STACKS:  stacks_ff <= csr_wdata[7:0];
            CSR_TEXTURE: tex_on_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage 1: range checks, angle and texture operands
   logic [7:0] slices, stacks;
   logic [8:0] j_up;
   logic       bad_in;

   always_comb begin
      slices = (32'(slices_ff) >= MAX_DIVISIONS) ? 8'(MAX_DIVISIONS - 1) : slices_ff;
      stacks = (32'(stacks_ff) >= MAX_DIVISIONS) ? 8'(MAX_DIVISIONS - 1) : stacks_ff;
      j_up   = 9'(req_stack_index) + 9'd1;
      bad_in = (slices < 8'd2) || (stacks == 8'd0) ||
               (req_stack_index >= stacks) || (req_slice_index > slices);
   end

   side_type            side1_ff;
   logic [ANG_DEN_W-1:0] th_a_ff, th_d_ff, phu_a_ff, phl_a_ff, ph_d_ff;
   logic [TNW-1:0]      tu_num_ff, tvu_num_ff, tvl_num_ff;
   logic [7:0]          sl_ff, st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff.valid <= 1'b0;
      end else begin
         side1_ff.valid <= start && !busy;
      end
      side1_ff.bad    <= bad_in;
      side1_ff.pole_u <= (j_up == 9'(stacks));
      side1_ff.pole_l <= (req_stack_index == 8'd0);
      // the last slice reuses slice zero so the seam closes
      th_a_ff  <= (req_slice_index == slices) ? '0 : 9'(req_slice_index);
      th_d_ff  <= 9'(slices);
      phu_a_ff <= j_up;
      phl_a_ff <= 9'(req_stack_index);
      ph_d_ff  <= {stacks, 1'b0};
      tu_num_ff  <= {1'b0, 8'(slices - req_slice_index), 16'd0} + TNW'(slices >> 1);
      tvu_num_ff <= {1'b0, 8'(9'(stacks) - j_up), 16'd0} + TNW'(stacks >> 1);
      tvl_num_ff <= {1'b0, 8'(stacks - req_stack_index), 16'd0} + TNW'(stacks >> 1);
      sl_ff <= slices;
      st_ff <= stacks;
   end

   // angles
   logic signed [31:0] sth, cth, sphu, cphu, sphl, cphl;

   uvs_sincos u_theta (
      .clock(clock), .ang_num(th_a_ff), .ang_den(th_d_ff),
      .sin_out(sth), .cos_out(cth)
   );

   uvs_sincos u_phi_up (
      .clock(clock), .ang_num(phu_a_ff), .ang_den(ph_d_ff),
      .sin_out(sphu), .cos_out(cphu)
   );

   uvs_sincos u_phi_lo (
      .clock(clock), .ang_num(phl_a_ff), .ang_den(ph_d_ff),
      .sin_out(sphl), .cos_out(cphl)
   );

   // texture dividers
   logic [TEX_QUO_W-1:0] tu_q, tvu_q, tvl_q;

   uvs_div #(.DEN_W(TEX_DEN_W), .QUO_W(TEX_QUO_W)) u_div_u (
      .clock(clock), .num_in(tu_num_ff), .den_in(sl_ff), .quo_out(tu_q)
   );

   uvs_div #(.DEN_W(TEX_DEN_W), .QUO_W(TEX_QUO_W)) u_div_vu (
      .clock(clock), .num_in(tvu_num_ff), .den_in(st_ff), .quo_out(tvu_q)
   );

   uvs_div #(.DEN_W(TEX_DEN_W), .QUO_W(TEX_QUO_W)) u_div_vl (
      .clock(clock), .num_in(tvl_num_ff), .den_in(st_ff), .quo_out(tvl_q)
   );

   // side band and texture alignment lines
   side_type side_ff [SC_LAT];
   tex_type  tex_ff  [TEX_DLY];

   for (genvar s = 0; s < SC_LAT; s++) begin : g_side
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) side_ff[s] <= '0;
            else       side_ff[s] <= side1_ff;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) side_ff[s] <= '0;
            else       side_ff[s] <= side_ff[s-1];
         end
      end
   end

   for (genvar s = 0; s < TEX_DLY; s++) begin : g_tex
      if (s == 0) begin : g_first
         always_ff @(posedge clock) tex_ff[s] <= '{u: tu_q, vu: tvu_q, vl: tvl_q};
      end else begin : g_next
         always_ff @(posedge clock) tex_ff[s] <= tex_ff[s-1];
      end
   end

   // V1: radius products, sin(phi) forced to zero at the poles
   side_type           v1_ff, v2_ff, v3_ff;
   logic signed [48:0] pru_ff, prl_ff, pzu_ff, pzl_ff;
   logic signed [31:0] sth1_ff, cth1_ff, sth2_ff, cth2_ff;
   logic signed [31:0] sphu_in, sphl_in;
   logic signed [16:0] rad_s;

   assign rad_s   = $signed({1'b0, radius_ff});
   assign sphu_in = side_ff[SC_LAT-1].pole_u ? '0 : sphu;
   assign sphl_in = side_ff[SC_LAT-1].pole_l ? '0 : sphl;

   always_ff @(posedge clock) begin
      pru_ff  <= rad_s * sphu_in;
      prl_ff  <= rad_s * sphl_in;
      pzu_ff  <= rad_s * cphu;
      pzl_ff  <= rad_s * cphl;
      sth1_ff <= sth;
      cth1_ff <= cth;
   end

   // V2: ring radius and z
   logic signed [31:0] rsu_ff, rsl_ff;
   logic signed [15:0] zu2_ff, zl2_ff, zu3_ff, zl3_ff;
   logic signed [63:0] rsu_in, rsl_in;

   assign rsu_in = rnd_shift(64'(pru_ff), 16);
   assign rsl_in = rnd_shift(64'(prl_ff), 16);

   always_ff @(posedge clock) begin
      rsu_ff  <= rsu_in[31:0];
      rsl_ff  <= rsl_in[31:0];
      zu2_ff  <= sat16(rnd_shift(64'(pzu_ff), 30));
      zl2_ff  <= sat16(rnd_shift(64'(pzl_ff), 30));
      sth2_ff <= sth1_ff;
      cth2_ff <= cth1_ff;
   end

   // V3: x and y products
   logic signed [63:0] pxu_ff, pyu_ff, pxl_ff, pyl_ff;

   always_ff @(posedge clock) begin
      pxu_ff <= 64'(rsu_ff) * 64'(sth2_ff);
      pyu_ff <= 64'(rsu_ff) * 64'(cth2_ff);
      pxl_ff <= 64'(rsl_ff) * 64'(sth2_ff);
      pyl_ff <= 64'(rsl_ff) * 64'(cth2_ff);
      zu3_ff <= zu2_ff;
      zl3_ff <= zl2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= '0;
         v2_ff <= '0;
         v3_ff <= '0;
      end else begin
         v1_ff <= side_ff[SC_LAT-1];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // output register
   logic    tex_keep;
   tex_type tex_out;

   assign tex_keep = tex_on_ff && !v3_ff.bad;
   assign tex_out  = tex_ff[TEX_DLY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= v3_ff.valid;
      end
      rsp_upper_x     <= v3_ff.bad ? '0 : sat16(rnd_shift(pxu_ff, 44));
      rsp_upper_y     <= v3_ff.bad ? '0 : sat16(rnd_shift(pyu_ff, 44));
      rsp_upper_z     <= v3_ff.bad ? '0 : zu3_ff;
      rsp_lower_x     <= v3_ff.bad ? '0 : sat16(rnd_shift(pxl_ff, 44));
      rsp_lower_y     <= v3_ff.bad ? '0 : sat16(rnd_shift(pyl_ff, 44));
      rsp_lower_z     <= v3_ff.bad ? '0 : zl3_ff;
      rsp_tex_u       <= tex_keep ? tex_out.u  : '0;
      rsp_tex_v_upper <= tex_keep ? tex_out.vu : '0;
      rsp_tex_v_lower <= tex_keep ? tex_out.vl : '0;
      rsp_tex_valid   <= tex_on_ff;
      rsp_bad_index   <= v3_ff.bad;
   end

endmodule

### tb/uv_sphere_strip_vertex_gen_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uv_sphere_strip_vertex_gen_tb
// Drives strip positions through the sphere vertex generator under several
// radius, count and texture settings, predicts each vertex pair and texture
// coordinate set in fixed point, and checks every result strobe in order.
// ----------------------------------------------------------------------------
module uv_sphere_strip_vertex_gen_tb;
   import uvs_pkg::*;

   localparam int PIPE_DRAIN = 80;
   localparam longint ONE_Q30 = 64'sd1 << 30;
   localparam longint HALF_PI = 64'sd1686629713;

   typedef struct {
      logic signed [15:0] ux, uy, uz, lx, ly, lz;
      logic [16:0] tu, tvu, tvl;
      logic tv, bad;
   } strip_vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [7:0] req_stack_index = '0;
   logic [7:0] req_slice_index = '0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic rsp_strobe;
   logic signed [15:0] rsp_upper_x, rsp_upper_y, rsp_upper_z;
   logic signed [15:0] rsp_lower_x, rsp_lower_y, rsp_lower_z;
   logic [16:0] rsp_tex_u, rsp_tex_v_upper, rsp_tex_v_lower;
   logic rsp_tex_valid, rsp_bad_index;

   // shadow copy of the configuration registers
   logic [15:0] sh_radius;
   logic [7:0]  sh_slices, sh_stacks;
   logic        sh_texture;

   strip_vertex_type pending_vertices[$];
   int mismatch_count = 0;

   uv_sphere_strip_vertex_gen dut (.*);

   initial forever #2 clock = ~clock;

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic longint mul_q30(longint a, longint b);
      return (a * b) / ONE_Q30;
   endfunction

   function automatic longint round_shift(longint v, int sh);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // sine and cosine in Q2.30 of the angle a/d of a full turn
   task automatic turn_sin_cos(input int unsigned a, input int unsigned d,
                               output longint sn, output longint cs);
      longint unsigned f, q, r;
      longint x, x2, t, s, c;
      if (d == 0) begin
         sn = 0; cs = ONE_Q30; return;
      end
      a = a % d;
      f = 4 * a;
      q = f / d;
      r = f - q * d;
      x = (r * HALF_PI + d / 2) / d;
      x2 = mul_q30(x, x);
      t = ONE_Q30 - x2 / 110;
      t = ONE_Q30 - mul_q30(x2, t) / 72;
      t = ONE_Q30 - mul_q30(x2, t) / 42;
      t = ONE_Q30 - mul_q30(x2, t) / 20;
      t = ONE_Q30 - mul_q30(x2, t) / 6;
      s = mul_q30(x, t);
      t = ONE_Q30 - x2 / 132;
      t = ONE_Q30 - mul_q30(x2, t) / 90;
      t = ONE_Q30 - mul_q30(x2, t) / 56;
      t = ONE_Q30 - mul_q30(x2, t) / 30;
      t = ONE_Q30 - mul_q30(x2, t) / 12;
      c = ONE_Q30 - mul_q30(x2, t) / 2;
      case (q & 3)
         0: begin sn = s;  cs = c;  end
         1: begin sn = c;  cs = -s; end
         2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endtask

   task automatic band_vertex(input int unsigned band, input int unsigned stacks,
                              input longint sth, input longint cth,
                              output logic signed [15:0] vx, vy, vz);
      longint sphi, cphi, rs;
      turn_sin_cos(band, 2 * stacks, sphi, cphi);
      if (band == 0 || band == stacks) sphi = 0;
      rs = round_shift(longint'(sh_radius) * sphi, 16);
      vx = clamp16(round_shift(rs * sth, 44));
      vy = clamp16(round_shift(rs * cth, 44));
      vz = clamp16(round_shift(longint'(sh_radius) * cphi, 30));
   endtask

   function automatic logic [16:0] tex_one_minus(int unsigned k, int unsigned n);
      return 17'(((longint'(n - k) << 16) + n / 2) / n);
   endfunction

   task automatic predict_strip_vertex(input int unsigned j, input int unsigned i,
                                       output strip_vertex_type e);
      int unsigned slices, stacks;
      longint sth, cth;
      slices = (sh_slices >= 240) ? 239 : sh_slices;
      stacks = (sh_stacks >= 240) ? 239 : sh_stacks;
      e = '{default: '0};
      e.tv = sh_texture;
      if (slices < 2 || stacks < 1 || j >= stacks || i > slices) begin
         e.bad = 1'b1;
         return;
      end
      turn_sin_cos((i == slices) ? 0 : i, slices, sth, cth);
      band_vertex(j + 1, stacks, sth, cth, e.ux, e.uy, e.uz);
      band_vertex(j, stacks, sth, cth, e.lx, e.ly, e.lz);
      if (sh_texture) begin
         e.tu = tex_one_minus(i, slices);
         e.tvu = tex_one_minus(j + 1, stacks);
         e.tvl = tex_one_minus(j, stacks);
      end
   endtask

   // idle cycles before a request; start only drops when there is a gap
   task automatic random_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if (n != 0) start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // one request transfer; gaps optional
   task automatic send_position(input logic [7:0] j, input logic [7:0] i,
                                input bit gaps);
      strip_vertex_type e;
      if (gaps) random_gap();
      start <= 1'b1;
      req_stack_index <= j;
      req_slice_index <= i;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_strip_vertex(j, i, e);
      pending_vertices = {pending_vertices, e};
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_RADIUS:  sh_radius = val;
         CSR_SLICES:  sh_slices = val[7:0];
         CSR_STACKS:  sh_stacks = val[7:0];
         CSR_TEXTURE: sh_texture = val[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain_pipe();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (pending_vertices.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (PIPE_DRAIN) @(negedge clock);
   endtask

   task automatic configure(input logic [15:0] rad, input logic [7:0] sl,
                            input logic [7:0] st, input logic tex);
      drain_pipe();
      write_csr(CSR_RADIUS, rad);
      write_csr(CSR_SLICES, {8'h00, sl});
      write_csr(CSR_STACKS, {8'h00, st});
      write_csr(CSR_TEXTURE, {15'd0, tex});
      csr_valid <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      strip_vertex_type e;
      if (!reset && rsp_strobe) begin
         if (pending_vertices.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result transfer");
         end else begin
            e = pending_vertices.pop_front();
            if ({rsp_upper_x, rsp_upper_y, rsp_upper_z, rsp_lower_x, rsp_lower_y,
                 rsp_lower_z, rsp_tex_u, rsp_tex_v_upper, rsp_tex_v_lower,
                 rsp_tex_valid, rsp_bad_index} !==
                {e.ux, e.uy, e.uz, e.lx, e.ly, e.lz, e.tu, e.tvu, e.tvl,
                 e.tv, e.bad}) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch exp %0d %0d %0d | %0d %0d %0d | %0d %0d %0d | %0b %0b",
                           e.ux, e.uy, e.uz, e.lx, e.ly, e.lz, e.tu, e.tvu, e.tvl,
                           e.tv, e.bad);
                  $display("         got %0d %0d %0d | %0d %0d %0d | %0d %0d %0d | %0b %0b",
                           rsp_upper_x, rsp_upper_y, rsp_upper_z,
                           rsp_lower_x, rsp_lower_y, rsp_lower_z, rsp_tex_u,
                           rsp_tex_v_upper, rsp_tex_v_lower, rsp_tex_valid,
                           rsp_bad_index);
               end
            end
         end
      end
   end

   task automatic test_reset_defaults();
      send_position(8'd0, 8'd0, 0);
      send_position(8'd31, 8'd32, 0);
      send_position(8'd32, 8'd0, 0);
      send_position(8'd0, 8'd33, 0);
   endtask

   task automatic test_directed_edges();
      configure(16'hffff, 8'd239, 8'd239, 1'b1);
      send_position(8'd0, 8'd0, 0);
      send_position(8'd238, 8'd239, 0);
      send_position(8'd119, 8'd60, 0);
      send_position(8'd60, 8'd180, 0);
      send_position(8'd239, 8'd0, 0);
      send_position(8'd255, 8'd255, 0);
      send_position(8'd0, 8'd240, 0);
      // large counts clip to the maximum
      configure(16'h0100, 8'd255, 8'd250, 1'b1);
      send_position(8'd238, 8'd239, 0);
      send_position(8'd100, 8'd10, 0);
      // invalid configurations
      configure(16'h0000, 8'd1, 8'd1, 1'b0);
      send_position(8'd0, 8'd0, 0);
      configure(16'h8000, 8'd2, 8'd0, 1'b1);
      send_position(8'd0, 8'd0, 0);
      // smallest valid sphere
      configure(16'h8000, 8'd2, 8'd1, 1'b1);
      send_position(8'd0, 8'd0, 0);
      send_position(8'd0, 8'd1, 0);
      send_position(8'd0, 8'd2, 0);
      send_position(8'd1, 8'd0, 0);
      send_position(8'd0, 8'd3, 0);
   endtask

   task automatic test_random_strips(input int n_items);
      for (int k = 0; k < n_items; k++) begin
         int unsigned sl, st;
         logic [7:0] j, i;
         if (k % 150 == 0) begin
            sl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(2, 40);
            st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(1, 40);
            configure(16'($urandom_range(0, 65535)), 8'(sl), 8'(st),
                      1'($urandom_range(0, 1)));
         end
         sl = (sh_slices >= 240) ? 239 : sh_slices;
         st = (sh_stacks >= 240) ? 239 : sh_stacks;
         if ($urandom_range(0, 9) == 0 || sl < 2 || st < 1) begin
            j = 8'($urandom_range(0, 255));
            i = 8'($urandom_range(0, 255));
         end else begin
            j = 8'($urandom_range(0, st - 1));
            i = 8'($urandom_range(0, sl));
         end
         // long back-to-back runs too
         send_position(j, i, (k / 64) % 3 != 0);
      end
   endtask

   initial begin
      sh_radius = RADIUS_RST;
      sh_slices = COUNT_RST;
      sh_stacks = COUNT_RST;
      sh_texture = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_edges();
      test_random_strips(1830);
      drain_pipe();
      if (mismatch_count == 0 && pending_vertices.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
